// ----- design/saka_calendar_converter_assert.svh -----
// ============================================================================
// Saka calendar converter assertion macros
// Shared property templates for the port-level checker of the converter.
// ============================================================================
`ifndef SAKA_CALENDAR_CONVERTER_ASSERT_SVH
`define SAKA_CALENDAR_CONVERTER_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define SCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saka_calendar_converter: property violated");

// Next-cycle implication under an active-low reset.
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saka_calendar_converter: property violated");

`endif

// ----- design/scc_pkg.sv -----
// ============================================================================
// Saka calendar converter package
// Types, formula constants and reciprocal multipliers shared by the datapaths.
// ============================================================================
package scc_pkg;

    localparam int NUM_STAGES = 8;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam logic [22:0] JD_FIRST  = 23'd1749630;
    localparam logic [22:0] JD_LAST   = 23'd5402054;
    localparam logic [22:0] JD_OFFSET = 23'd68518;
    localparam logic [22:0] JD_EPOCH  = 23'd1749579;

    localparam logic [13:0] YEAR_LAST  = 14'd9999;
    localparam logic [13:0] YEAR_SHIFT = 14'd78;
    localparam logic [15:0] YEAR_BIAS  = 16'(100 * 49 + 78);

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_LAST  = 4'd12;

    localparam logic [17:0] DAYS_400Y     = 18'd146097;
    localparam logic [10:0] DAYS_4Y       = 11'd1461;
    localparam logic [8:0]  LONG_START    = 9'd185;
    localparam logic [8:0]  LEAP_DAY      = 9'd366;
    localparam logic [8:0]  SHORT_BASE    = 9'd156;

    // Exact floor division by reciprocal multiplication over the bounded input width.
    localparam int          DIV_N_SHIFT = 41;
    localparam logic [25:0] DIV_N_MUL   =
        26'(((64'd1 << DIV_N_SHIFT) * 64'd4 + 64'd146096) / 64'd146097);

    localparam int          DIV_I_SHIFT = 38;
    localparam logic [29:0] DIV_I_MUL   =
        30'(((64'd1 << DIV_I_SHIFT) * 64'd4000 + 64'd1461000) / 64'd1461001);

    localparam int          DIV_C_SHIFT = 21;
    localparam logic [14:0] DIV_C_MUL   = 15'(((64'd1 << DIV_C_SHIFT) + 64'd99) / 64'd100);

    localparam int          DIV_S_SHIFT = 14;
    localparam logic [9:0]  DIV_31_MUL  = 10'(((64'd1 << DIV_S_SHIFT) + 64'd30) / 64'd31);
    localparam logic [9:0]  DIV_30_MUL  = 10'(((64'd1 << DIV_S_SHIFT) + 64'd29) / 64'd30);

    typedef struct packed {
        logic [22:0] day_number;
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        leap_year;
        logic [4:0]  month_length;
        logic        range_error;
    } result_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        if (month == MONTH_FIRST)
        begin
            days = leap ? 5'd31 : 5'd30;
        end
        else if (month inside {[4'd2:4'd6]})
        begin
            days = 5'd31;
        end
        else
        begin
            days = 5'd30;
        end
        return days;
    endfunction

endpackage

// ----- design/saka_calendar_converter.sv -----
// ============================================================================
// Saka calendar converter
// Converts a Julian day number to a Saka date or a Saka date to a Julian day
// number, with leap flag, month length and range flag, in an eight-stage pipe.
//
// Channel  Side    One transaction carries
// s_axis   input   command in tuser, day number and date fields in tdata
// m_axis   output  range flag in tuser, day number, date, leap, length in tdata
//
// A result passes through the eight register stages before it is offered, and one
// request can be accepted in every cycle unless a stalled output has filled every stage.
// Reset clears only the stage valid bits, so the pipe comes up empty.
// Each stage loads when it is empty or its successor loads, so a stalled
// output still lets requests fill empty stages and nothing is lost or repeated.
// ============================================================================
module saka_calendar_converter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // day_number_in[22:0], year_in[37:23], month_in[41:38], day_in[46:42], zero[47]
    input  logic [scc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command[0]
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // day_number_out[22:0], year_out[37:23], month_out[41:38], day_out[46:42],
    // leap_year[47], month_length[52:48], zero[55:53]
    output logic [scc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // range_error[0]
    output logic [0:0]                     m_axis_tuser
);

    localparam int N = scc_pkg::NUM_STAGES;

    logic [N-1:0]     stage_en;
    logic             cmd_reg [0:N-2];
    scc_pkg::result_t date_res;
    scc_pkg::result_t jdn_res;
    scc_pkg::result_t out_reg, out_next;

    scc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .stage_en  (stage_en)
    );

    scc_to_date u_to_date (
        .clk        (clk),
        .stage_en   (stage_en),
        .day_number (s_axis_tdata[22:0]),
        .result     (date_res)
    );

    scc_to_jdn u_to_jdn (
        .clk      (clk),
        .stage_en (stage_en),
        .year     (s_axis_tdata[37:23]),
        .month    (s_axis_tdata[41:38]),
        .day      (s_axis_tdata[46:42]),
        .result   (jdn_res)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            cmd_reg[0] <= s_axis_tuser[0];
        end
        for (int k = 1; k < N - 1; k++)
        begin
            if (stage_en[k])
            begin
                cmd_reg[k] <= cmd_reg[k-1];
            end
        end
    end

    assign out_next = cmd_reg[N-2] ? jdn_res : date_res;

    always_ff @(posedge clk)
    begin
        if (stage_en[N-1])
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tdata = {3'b000, out_reg.month_length, out_reg.leap_year, out_reg.day,
                           out_reg.month, out_reg.year, out_reg.day_number};
    assign m_axis_tuser = out_reg.range_error;

endmodule

// ----- design/scc_pipe_ctrl.sv -----
// ============================================================================
// Saka calendar converter pipeline control
// Per-stage valid bits and load enables; a stage loads when it is empty or
// when the stage after it loads, so bubbles close up under a stalled output.
// ============================================================================
module scc_pipe_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [scc_pkg::NUM_STAGES-1:0] stage_en
);

    localparam int N = scc_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;

    always_comb
    begin
        stage_en[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[0] = stage_en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < N; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[N-1];

endmodule

// ----- design/scc_to_date.sv -----
// ============================================================================
// Saka calendar converter, day number to date
// Seven register stages: offset, 400-year cycle, cycle remainder, 4-year
// cycle, day of year, month index, and final date with leap flag.
// ============================================================================
module scc_to_date (
    input  logic                           clk,
    input  logic [scc_pkg::NUM_STAGES-1:0] stage_en,
    input  logic [22:0]                    day_number,
    output scc_pkg::result_t               result
);

    logic [22:0] l0_0_reg, l0_0_next;
    logic        err_0_reg, err_0_next;

    logic [7:0]  n_1_reg, n_1_next;
    logic [22:0] l0_1_reg;
    logic        err_1_reg;
    logic [48:0] prod_n;

    logic [15:0] l1_2_reg, l1_2_next;
    logic [7:0]  n_2_reg;
    logic        err_2_reg;
    logic [25:0] cycle_days;

    logic [6:0]  i_3_reg, i_3_next;
    logic [15:0] l1_3_reg;
    logic [7:0]  n_3_reg;
    logic        err_3_reg;
    logic [16:0] l1_inc;
    logic [46:0] prod_i;

    logic [8:0]  l2_4_reg, l2_4_next;
    logic [6:0]  i_4_reg;
    logic [7:0]  n_4_reg;
    logic        err_4_reg;
    logic [17:0] quad_days;

    logic [3:0]  j_5_reg, j_5_next;
    logic [8:0]  l2_5_reg;
    logic [6:0]  i_5_reg;
    logic [7:0]  n_5_reg;
    logic        err_5_reg;
    logic [8:0]  lo_arg;
    logic [8:0]  hi_arg;
    logic [18:0] prod_lo;
    logic [18:0] prod_hi;
    logic        long_part;
    logic        last_day;

    scc_pkg::result_t res_6_reg, res_6_next;
    logic [8:0]  day_sum;
    logic [8:0]  day_adj;
    logic        wrap;
    logic [3:0]  month_val;
    logic [6:0]  cy;
    logic        century;
    logic [15:0] year_val;
    logic [1:0]  cent_mod;
    logic        leap;

    always_comb
    begin
        l0_0_next  = day_number + scc_pkg::JD_OFFSET;
        err_0_next = (day_number < scc_pkg::JD_FIRST) || (day_number > scc_pkg::JD_LAST);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            l0_0_reg  <= l0_0_next;
            err_0_reg <= err_0_next;
        end
    end

    always_comb
    begin
        prod_n   = 49'(l0_0_reg) * 49'(scc_pkg::DIV_N_MUL);
        n_1_next = prod_n[scc_pkg::DIV_N_SHIFT+7:scc_pkg::DIV_N_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            n_1_reg   <= n_1_next;
            l0_1_reg  <= l0_0_reg;
            err_1_reg <= err_0_reg;
        end
    end

    always_comb
    begin
        cycle_days = 26'(scc_pkg::DAYS_400Y) * 26'(n_1_reg) + 26'd3;
        l1_2_next  = 16'(l0_1_reg - 23'(cycle_days >> 2));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            l1_2_reg  <= l1_2_next;
            n_2_reg   <= n_1_reg;
            err_2_reg <= err_1_reg;
        end
    end

    always_comb
    begin
        l1_inc   = 17'(l1_2_reg) + 17'd1;
        prod_i   = 47'(l1_inc) * 47'(scc_pkg::DIV_I_MUL);
        i_3_next = prod_i[scc_pkg::DIV_I_SHIFT+6:scc_pkg::DIV_I_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            i_3_reg   <= i_3_next;
            l1_3_reg  <= l1_2_reg;
            n_3_reg   <= n_2_reg;
            err_3_reg <= err_2_reg;
        end
    end

    always_comb
    begin
        quad_days = 18'(scc_pkg::DAYS_4Y) * 18'(i_3_reg);
        l2_4_next = 9'(17'(l1_3_reg) + 17'd1 - 17'(quad_days >> 2));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            l2_4_reg  <= l2_4_next;
            i_4_reg   <= i_3_reg;
            n_4_reg   <= n_3_reg;
            err_4_reg <= err_3_reg;
        end
    end

    always_comb
    begin
        lo_arg    = l2_4_reg - 9'd1;
        hi_arg    = l2_4_reg - scc_pkg::SHORT_BASE;
        prod_lo   = 19'(lo_arg) * 19'(scc_pkg::DIV_31_MUL);
        prod_hi   = 19'(hi_arg) * 19'(scc_pkg::DIV_30_MUL);
        long_part = l2_4_reg >= scc_pkg::LONG_START;
        last_day  = l2_4_reg >= scc_pkg::LEAP_DAY;
        if (long_part)
        begin
            j_5_next = 4'(prod_hi[scc_pkg::DIV_S_SHIFT+3:scc_pkg::DIV_S_SHIFT] + 4'd5
                          - {3'b000, last_day});
        end
        else
        begin
            j_5_next = prod_lo[scc_pkg::DIV_S_SHIFT+3:scc_pkg::DIV_S_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            j_5_reg   <= j_5_next;
            l2_5_reg  <= l2_4_reg;
            i_5_reg   <= i_4_reg;
            n_5_reg   <= n_4_reg;
            err_5_reg <= err_4_reg;
        end
    end

    always_comb
    begin
        day_adj   = (j_5_reg >= 4'd6) ? 9'({5'b00000, j_5_reg} - 9'd5) : 9'd0;
        day_sum   = l2_5_reg - 9'(j_5_reg) * 9'd31 + day_adj;
        wrap      = j_5_reg >= 4'd11;
        month_val = 4'(j_5_reg + 4'd2 - (wrap ? 4'd12 : 4'd0));
        cy        = 7'(i_5_reg + {6'b000000, wrap});
        century   = cy == 7'd100;
        year_val  = 16'(16'd100 * 16'(n_5_reg) + 16'(cy) - scc_pkg::YEAR_BIAS);
        cent_mod  = 2'(n_5_reg[1:0] + {1'b0, century} + 2'd3);
        leap      = (cy[1:0] == 2'd0) && (((cy != 7'd0) && !century) || (cent_mod == 2'd0));

        res_6_next = '0;
        if (err_5_reg)
        begin
            res_6_next.range_error = 1'b1;
        end
        else
        begin
            res_6_next.year         = year_val[14:0];
            res_6_next.month        = month_val;
            res_6_next.day          = day_sum[4:0];
            res_6_next.leap_year    = leap;
            res_6_next.month_length = scc_pkg::month_days(month_val, leap);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            res_6_reg <= res_6_next;
        end
    end

    assign result = res_6_reg;

endmodule

// ----- design/scc_to_jdn.sv -----
// ============================================================================
// Saka calendar converter, date to day number
// Seven register stages: range check and shifted year, century quotient,
// leap flag and corrections, partial sums, final sum, then alignment stages.
// ============================================================================
module scc_to_jdn (
    input  logic                           clk,
    input  logic [scc_pkg::NUM_STAGES-1:0] stage_en,
    input  logic [14:0]                    year,
    input  logic [3:0]                     month,
    input  logic [4:0]                     day,
    output scc_pkg::result_t               result
);

    logic [13:0] y_0_reg;
    logic [3:0]  m_0_reg;
    logic [4:0]  d_0_reg;
    logic        err_0_reg, err_0_next;
    logic [13:0] g_0_reg, g_0_next;
    logic        m1_0_reg, m1_0_next;

    logic [6:0]  q_1_reg, q_1_next;
    logic [13:0] y_1_reg;
    logic [3:0]  m_1_reg;
    logic [4:0]  d_1_reg;
    logic        err_1_reg;
    logic [13:0] g_1_reg;
    logic        m1_1_reg;
    logic [28:0] prod_c;

    logic [6:0]  tq_2_reg, tq_2_next;
    logic [13:0] t_2_reg, t_2_next;
    logic        leap_2_reg, leap_2_next;
    logic [13:0] y_2_reg;
    logic [3:0]  m_2_reg;
    logic [4:0]  d_2_reg;
    logic        err_2_reg;
    logic [13:0] rem;
    logic        rem_zero;

    logic [23:0] a_3_reg, a_3_next;
    logic [8:0]  bpos_3_reg, bpos_3_next;
    logic [7:0]  bneg_3_reg, bneg_3_next;
    logic        leap_3_reg;
    logic [13:0] y_3_reg;
    logic [3:0]  m_3_reg;
    logic [4:0]  d_3_reg;
    logic        err_3_reg;
    logic [8:0]  cent_corr;

    scc_pkg::result_t res_4_reg, res_4_next;
    scc_pkg::result_t res_5_reg;
    scc_pkg::result_t res_6_reg;

    always_comb
    begin
        err_0_next = year[14] || (year[13:0] > scc_pkg::YEAR_LAST)
                     || (month < scc_pkg::MONTH_FIRST) || (month > scc_pkg::MONTH_LAST);
        g_0_next   = year[13:0] + scc_pkg::YEAR_SHIFT;
        m1_0_next  = month == scc_pkg::MONTH_FIRST;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            y_0_reg   <= year[13:0];
            m_0_reg   <= month;
            d_0_reg   <= day;
            err_0_reg <= err_0_next;
            g_0_reg   <= g_0_next;
            m1_0_reg  <= m1_0_next;
        end
    end

    always_comb
    begin
        prod_c   = 29'(g_0_reg) * 29'(scc_pkg::DIV_C_MUL);
        q_1_next = prod_c[scc_pkg::DIV_C_SHIFT+6:scc_pkg::DIV_C_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            q_1_reg   <= q_1_next;
            y_1_reg   <= y_0_reg;
            m_1_reg   <= m_0_reg;
            d_1_reg   <= d_0_reg;
            err_1_reg <= err_0_reg;
            g_1_reg   <= g_0_reg;
            m1_1_reg  <= m1_0_reg;
        end
    end

    always_comb
    begin
        rem         = g_1_reg - 14'(q_1_reg) * 14'd100;
        rem_zero    = rem == 14'd0;
        tq_2_next   = (m1_1_reg && rem_zero) ? 7'(q_1_reg - 7'd1) : q_1_reg;
        t_2_next    = g_1_reg - {13'd0, m1_1_reg};
        leap_2_next = (g_1_reg[1:0] == 2'd0) && (!rem_zero || (q_1_reg[1:0] == 2'd0));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            tq_2_reg   <= tq_2_next;
            t_2_reg    <= t_2_next;
            leap_2_reg <= leap_2_next;
            y_2_reg    <= y_1_reg;
            m_2_reg    <= m_1_reg;
            d_2_reg    <= d_1_reg;
            err_2_reg  <= err_1_reg;
        end
    end

    always_comb
    begin
        a_3_next    = 24'(y_2_reg) * 24'd365 + 24'(t_2_reg >> 2) + 24'(d_2_reg)
                      + 24'(scc_pkg::JD_EPOCH);
        bpos_3_next = 9'(m_2_reg) * 9'd31;
        cent_corr   = (9'(tq_2_reg) + 9'd1) * 9'd3;
        bneg_3_next = 8'({7'd0, m_2_reg >= 4'd2})
                      + ((m_2_reg >= 4'd7) ? 8'(m_2_reg - 4'd7) : 8'd0)
                      + 8'(cent_corr[8:2]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            a_3_reg    <= a_3_next;
            bpos_3_reg <= bpos_3_next;
            bneg_3_reg <= bneg_3_next;
            leap_3_reg <= leap_2_reg;
            y_3_reg    <= y_2_reg;
            m_3_reg    <= m_2_reg;
            d_3_reg    <= d_2_reg;
            err_3_reg  <= err_2_reg;
        end
    end

    always_comb
    begin
        res_4_next = '0;
        if (err_3_reg)
        begin
            res_4_next.range_error = 1'b1;
        end
        else
        begin
            res_4_next.day_number   = 23'(a_3_reg + 24'(bpos_3_reg) - 24'(bneg_3_reg));
            res_4_next.year         = 15'(y_3_reg);
            res_4_next.month        = m_3_reg;
            res_4_next.day          = d_3_reg;
            res_4_next.leap_year    = leap_3_reg;
            res_4_next.month_length = scc_pkg::month_days(m_3_reg, leap_3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            res_4_reg <= res_4_next;
        end
        if (stage_en[5])
        begin
            res_5_reg <= res_4_reg;
        end
        if (stage_en[6])
        begin
            res_6_reg <= res_5_reg;
        end
    end

    assign result = res_6_reg;

endmodule

// ----- design/scc_checker.sv -----
// ============================================================================
// Saka calendar converter port checker
// Watches the result channel for consistent error reporting, legal date
// fields and a held result while the consumer stalls, and checks that the
// input is ready whenever the output has room.
// ============================================================================
`include "saka_calendar_converter_assert.svh"

module scc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [scc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser
);

    logic                           good_out;
    logic                           bad_out;
    logic                           out_stall;
    logic                           room;
    logic                           month_ok;
    logic                           length_ok;
    logic [scc_pkg::OUT_DATA_W:0]   out_word;

    assign good_out  = m_axis_tvalid && !m_axis_tuser[0];
    assign bad_out   = m_axis_tvalid && m_axis_tuser[0];
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign room      = !m_axis_tvalid || m_axis_tready;
    assign month_ok  = (m_axis_tdata[41:38] != 4'd0) && (m_axis_tdata[41:38] <= 4'd12);
    assign length_ok = (m_axis_tdata[52:48] == 5'd30) || (m_axis_tdata[52:48] == 5'd31);
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    `SCC_ASSERT_IMPLY(a_error_zeroes_data, clk, rst_n, bad_out, m_axis_tdata == '0)
    `SCC_ASSERT_IMPLY(a_month_legal, clk, rst_n, good_out, month_ok)
    `SCC_ASSERT_IMPLY(a_length_legal, clk, rst_n, good_out, length_ok)
    `SCC_ASSERT_NEXT(a_result_held, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))
    `SCC_ASSERT_IMPLY(a_ready_with_room, clk, rst_n, room, s_axis_tready)

endmodule

bind saka_calendar_converter scc_checker u_scc_checker (.*);
